FILE: src/rpi_pkg.sv
// Shared types, constants and tables for the lidar range-image projection block.
// Depends on nothing; every other file imports it.
package rpi_pkg;

  localparam int ROWS    = 64;
  localparam int COLUMNS = 1800;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);

  // Square root: one result bit per stage.
  localparam int SQ_STAGES = 30;
  localparam int SQ_RES_W  = SQ_STAGES;
  localparam int SQ_REM_W  = SQ_RES_W + 2;
  localparam int SQ_RAD_W  = 2 * SQ_STAGES;
  localparam int R2_W      = 40;

  // CORDIC datapath.
  localparam int CORDIC_ITERS = 20;
  localparam int CW           = 34;
  localparam int ACC_W        = 28;
  localparam int VW           = ACC_W - 7;

  // Row and column arithmetic.
  localparam int MW         = 24;
  localparam int D_W        = 13;
  localparam int AD_W       = 19;
  localparam int CN_W       = 20;
  localparam int DIV_STAGES = CN_W;
  localparam int RREM_W     = 22;
  localparam int QW         = 22;

  // Register loads from an accepted request to its result strobe.
  localparam int LATENCY = 2 + 1 + SQ_STAGES + 1 + CORDIC_ITERS + 3 + DIV_STAGES + 3;

  localparam logic signed [ACC_W-1:0] ACC_90 = 28'sd23040000;

  localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    28'sd11520000, 28'sd6800653, 28'sd3593278, 28'sd1824004, 28'sd915542,
    28'sd458217, 28'sd229164, 28'sd114589, 28'sd57295, 28'sd28648,
    28'sd14324, 28'sd7162, 28'sd3581, 28'sd1790, 28'sd895,
    28'sd448, 28'sd224, 28'sd112, 28'sd56, 28'sd28
  };

  // Upper limits of the vertical bands in millidegrees.
  localparam logic signed [VW-1:0] BAND_LIMIT [7] = '{
    -21'sd19000, -21'sd14000, -21'sd6000, 21'sd2000, 21'sd3000, 21'sd5000, 21'sd11000
  };

  // Per band slope divisor and the folded offset (off * D - C).
  localparam logic [D_W-1:0] BAND_D [8] = '{
    13'd6000, 13'd5000, 13'd1000, 13'd167, 13'd1000, 13'd2000, 13'd3000, 13'd4000
  };
  localparam logic signed [MW-1:0] BAND_K [8] = '{
    24'sd0, 24'sd4000, -24'sd8000, -24'sd17163, 24'sd32000, 24'sd92000,
    24'sd153000, 24'sd216000
  };

  // Register map, word index from paddr[3:2].
  localparam logic [1:0] REG_BOTTOM_ANGLE = 2'd0;
  localparam logic [1:0] REG_COL_RES      = 2'd1;
  localparam logic [1:0] REG_MIN_RANGE    = 2'd2;

  localparam logic [16:0] BOTTOM_ANGLE_RST = 17'd25000;
  localparam logic [11:0] COL_RES_RST      = 12'd200;
  localparam logic [13:0] MIN_RANGE_RST    = 14'd1500;

  typedef struct packed {
    logic [16:0] bottom_angle_offset;
    logic [11:0] column_resolution;
    logic [13:0] min_planar_range;
  } cfg_t;

  typedef struct packed {
    logic               range_ok;
    logic signed [20:0] xr;
    logic signed [19:0] yr;
    logic signed [19:0] zr;
    logic [7:0]         inten;
  } pass_t;

  typedef struct packed {
    logic [R2_W-1:0] r2;
    pass_t           pass;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
  } cvec_t;

endpackage

FILE: src/rpi_front.sv
// Front end: rotates the axes, squares the planar coordinates and classifies
// the request against the minimum planar range. Uses rpi_pkg.
module rpi_front import rpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic signed [19:0] x_in,
  input  logic signed [19:0] y_in,
  input  logic signed [19:0] z_in,
  input  logic [7:0]         intensity_in,
  input  logic [13:0]        min_planar_range,
  output logic               out_vld,
  output item_t              out_item
);

  logic               s1_vld;
  logic [R2_W-1:0]    s1_sqx;
  logic [R2_W-1:0]    s1_sqy;
  pass_t              s1_pass;
  pass_t              s2_pass;
  logic [27:0]        mr_sq;
  logic signed [20:0] xr;
  logic signed [41:0] px;
  logic signed [41:0] py;
  logic [R2_W-1:0]    r2;

  assign xr = -$signed({y_in[19], y_in});
  assign px = xr * xr;
  assign py = x_in * x_in;
  assign r2 = s1_sqx + s1_sqy;

  always_comb begin
    s2_pass          = s1_pass;
    s2_pass.range_ok = r2 >= {12'd0, mr_sq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      s1_vld  <= take;
      out_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    mr_sq         <= min_planar_range * min_planar_range;
    s1_sqx        <= px[R2_W-1:0];
    s1_sqy        <= py[R2_W-1:0];
    s1_pass.range_ok <= 1'b0;
    s1_pass.xr    <= xr;
    s1_pass.yr    <= x_in;
    s1_pass.zr    <= z_in;
    s1_pass.inten <= intensity_in;
    out_item.r2   <= r2;
    out_item.pass <= s2_pass;
  end

endmodule

FILE: src/rpi_queue.sv
// Two-entry queue between the front end and the projection back end.
// Uses rpi_pkg for the item type.
module rpi_queue import rpi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  out_vld,
  output item_t out_item
);

  item_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;
  logic       wr_en;

  // The back end never stalls, so any stored request leaves at once.
  assign pop      = cnt != 2'd0;
  assign wr_en    = push && !full;
  assign full     = cnt == 2'd2;
  assign out_vld  = pop;
  assign out_item = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, wr_en} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_mem[wr_ptr] <= push_item;
  end

endmodule

FILE: src/rpi_sqrt.sv
// Pipelined integer square root of the planar range squared, scaled by 2^20.
// One root bit per stage. Uses rpi_pkg.
module rpi_sqrt import rpi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  item_t               in_item,
  output logic                out_vld,
  output pass_t               out_pass,
  output logic [SQ_RES_W-1:0] out_root
);

  logic                sq_vld  [SQ_STAGES];
  logic [SQ_RAD_W-1:0] sq_rad  [SQ_STAGES];
  logic [SQ_REM_W-1:0] sq_rem  [SQ_STAGES];
  logic [SQ_RES_W-1:0] sq_res  [SQ_STAGES];
  pass_t               sq_pass [SQ_STAGES];

  genvar s;
  for (s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic                vld_i;
    logic [SQ_RAD_W-1:0] rad_i;
    logic [SQ_REM_W-1:0] rem_i;
    logic [SQ_RES_W-1:0] res_i;
    pass_t               pass_i;
    logic [SQ_REM_W+1:0] rem_t;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;

    if (s == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rad_i  = {in_item.r2, 20'd0};
      assign rem_i  = '0;
      assign res_i  = '0;
      assign pass_i = in_item.pass;
    end else begin : g_next
      assign vld_i  = sq_vld[s-1];
      assign rad_i  = sq_rad[s-1];
      assign rem_i  = sq_rem[s-1];
      assign res_i  = sq_res[s-1];
      assign pass_i = sq_pass[s-1];
    end

    assign rem_t = {rem_i, rad_i[SQ_RAD_W-1 -: 2]};
    assign trial = {2'b00, res_i, 2'b01};
    assign diff  = rem_t - trial;
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[s] <= 1'b0;
      else sq_vld[s] <= vld_i;
    end

    always_ff @(posedge clk) begin
      sq_rad[s]  <= {rad_i[SQ_RAD_W-3:0], 2'b00};
      sq_rem[s]  <= ge ? diff[SQ_REM_W-1:0] : rem_t[SQ_REM_W-1:0];
      sq_res[s]  <= {res_i[SQ_RES_W-2:0], ge};
      sq_pass[s] <= pass_i;
    end
  end

  assign out_vld  = sq_vld[SQ_STAGES-1];
  assign out_pass = sq_pass[SQ_STAGES-1];
  assign out_root = sq_res[SQ_STAGES-1];

endmodule

FILE: src/rpi_cordic.sv
// Two vectoring CORDIC pipelines side by side: vertical angle on (range, z)
// and horizontal angle on the rotated plane point. Uses rpi_pkg.
module rpi_cordic import rpi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  pass_t                   in_pass,
  input  logic [SQ_RES_W-1:0]     in_root,
  output logic                    out_vld,
  output pass_t                   out_pass,
  output logic signed [ACC_W-1:0] out_acc_v,
  output logic signed [ACC_W-1:0] out_acc_h
);

  function automatic cvec_t cstep(cvec_t c, int i);
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    cvec_t r;
    sx = c.x >>> i;
    sy = c.y >>> i;
    r  = c;
    if (c.y > 0) begin
      r.x   = c.x + sy;
      r.y   = c.y - sx;
      r.acc = c.acc + ATAN_TAB[i];
    end else if (c.y < 0) begin
      r.x   = c.x - sy;
      r.y   = c.y + sx;
      r.acc = c.acc - ATAN_TAB[i];
    end
    return r;
  endfunction

  logic  c_vld  [CORDIC_ITERS+1];
  pass_t c_pass [CORDIC_ITERS+1];
  cvec_t cv     [CORDIC_ITERS+1];
  cvec_t ch     [CORDIC_ITERS+1];

  logic signed [CW-1:0] a;
  logic signed [CW-1:0] b;
  cvec_t                v0;
  cvec_t                h0;

  assign a = {{(CW-31){in_pass.xr[20]}}, in_pass.xr, 10'd0};
  assign b = {{(CW-30){in_pass.yr[19]}}, in_pass.yr, 10'd0};

  // Points behind the sensor are turned by a quarter turn first so the
  // CORDIC always starts in the right half plane.
  always_comb begin
    v0.x   = {{(CW-SQ_RES_W){1'b0}}, in_root};
    v0.y   = {{(CW-30){in_pass.zr[19]}}, in_pass.zr, 10'd0};
    v0.acc = '0;
    h0.x   = b;
    h0.y   = a;
    h0.acc = '0;
    if (b < 0) begin
      if (a >= 0) begin
        h0.x   = a;
        h0.y   = -b;
        h0.acc = ACC_90;
      end else begin
        h0.x   = -a;
        h0.y   = b;
        h0.acc = -ACC_90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld[0] <= 1'b0;
    else c_vld[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    c_pass[0] <= in_pass;
    cv[0]     <= v0;
    ch[0]     <= h0;
  end

  genvar i;
  for (i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) c_vld[i+1] <= 1'b0;
      else c_vld[i+1] <= c_vld[i];
    end

    always_ff @(posedge clk) begin
      c_pass[i+1] <= c_pass[i];
      cv[i+1]     <= cstep(cv[i], i);
      ch[i+1]     <= cstep(ch[i], i);
    end
  end

  assign out_vld   = c_vld[CORDIC_ITERS];
  assign out_pass  = c_pass[CORDIC_ITERS];
  assign out_acc_v = cv[CORDIC_ITERS].acc;
  assign out_acc_h = ch[CORDIC_ITERS].acc;

endmodule

FILE: src/rpi_index.sv
// Back end: turns the two angles into row and column through banded row
// mapping and a pipelined column divider, then forms the result. Uses rpi_pkg.
module rpi_index import rpi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_vld,
  input  pass_t                   in_pass,
  input  logic signed [ACC_W-1:0] in_acc_v,
  input  logic signed [ACC_W-1:0] in_acc_h,
  output logic                    done,
  output logic                    point_valid,
  output logic [5:0]              row,
  output logic [10:0]             column,
  output logic [16:0]             cell_index,
  output logic signed [19:0]      x_out,
  output logic signed [19:0]      y_out,
  output logic signed [19:0]      z_out,
  output logic [7:0]              intensity_out
);

  localparam logic signed [QW-1:0] HALF_COLS = QW'(COLUMNS / 2);
  localparam logic signed [QW-1:0] COLS_S    = QW'(COLUMNS);
  localparam logic [12:0]          COLS_U    = 13'(COLUMNS);
  localparam int                   PW        = ROW_W + 14;

  // Stage A: round both angles to millidegrees.
  logic                  a_vld;
  pass_t                 a_pass;
  logic signed [VW-1:0]  a_v;
  logic signed [VW-1:0]  a_h;
  logic signed [ACC_W:0] tv;
  logic signed [ACC_W:0] th;

  assign tv = {in_acc_v[ACC_W-1], in_acc_v} + (ACC_W+1)'(128);
  assign th = {in_acc_h[ACC_W-1], in_acc_h} + (ACC_W+1)'(128);

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else a_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    a_pass <= in_pass;
    a_v    <= tv[ACC_W:8];
    a_h    <= th[ACC_W:8];
  end

  // Stage B: band lookup and the azimuth offset from straight ahead.
  logic                  b_vld;
  pass_t                 b_pass;
  logic signed [MW-1:0]  b_m;
  logic [D_W-1:0]        b_d;
  logic [AD_W-1:0]       b_ad;
  logic                  b_neg;
  logic [11:0]           b_res;
  logic [2:0]            band;
  logic signed [MW-1:0]  dd;
  logic signed [MW-1:0]  add;

  always_comb begin
    band = 3'd0;
    for (int j = 0; j < 7; j++) begin
      if (a_v >= BAND_LIMIT[j]) band = band + 3'd1;
    end
  end

  assign dd  = MW'(a_h) - MW'(90000);
  assign add = dd < 0 ? -dd : dd;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    b_pass <= a_pass;
    b_m    <= MW'(a_v) + $signed({7'd0, cfg.bottom_angle_offset}) + BAND_K[band];
    b_d    <= BAND_D[band];
    b_neg  <= dd < 0;
    b_ad   <= add[AD_W-1:0];
    b_res  <= (cfg.column_resolution == 12'd0) ? 12'd1 : cfg.column_resolution;
  end

  // Stage C: row range check and divider operands.
  logic                 c_vld;
  pass_t                c_pass;
  logic                 c_ok;
  logic [RREM_W-1:0]    c_rnum;
  logic [D_W-1:0]       c_d;
  logic [CN_W-1:0]      c_cn;
  logic [D_W-1:0]       c_cd;
  logic                 c_neg;
  logic [MW-1:0]        lim;
  logic signed [MW-1:0] neg_d;

  assign lim   = MW'(b_d) * MW'(ROWS);
  assign neg_d = -$signed(MW'(b_d));

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    c_pass <= b_pass;
    c_ok   <= b_pass.range_ok && (b_m > neg_d) && (b_m < $signed(lim));
    c_rnum <= b_m < 0 ? '0 : b_m[RREM_W-1:0];
    c_d    <= b_d;
    c_cn   <= CN_W'({b_ad, 1'b0}) + CN_W'(b_res);
    c_cd   <= {b_res, 1'b0};
    c_neg  <= b_neg;
  end

  // Division stages: the column quotient takes one bit per stage, the row
  // quotient uses the first ROW_W of them.
  logic              dv_vld  [DIV_STAGES];
  pass_t             dv_pass [DIV_STAGES];
  logic              dv_ok   [DIV_STAGES];
  logic              dv_neg  [DIV_STAGES];
  logic [RREM_W-1:0] dv_rrem [DIV_STAGES];
  logic [ROW_W-1:0]  dv_rq   [DIV_STAGES];
  logic [D_W-1:0]    dv_d    [DIV_STAGES];
  logic [D_W-1:0]    dv_crem [DIV_STAGES];
  logic [CN_W-1:0]   dv_cn   [DIV_STAGES];
  logic [CN_W-1:0]   dv_cq   [DIV_STAGES];
  logic [D_W-1:0]    dv_cd   [DIV_STAGES];

  genvar s;
  for (s = 0; s < DIV_STAGES; s++) begin : g_div
    logic              vld_i;
    pass_t             pass_i;
    logic              ok_i;
    logic              neg_i;
    logic [RREM_W-1:0] rrem_i;
    logic [ROW_W-1:0]  rq_i;
    logic [D_W-1:0]    d_i;
    logic [D_W-1:0]    crem_i;
    logic [CN_W-1:0]   cn_i;
    logic [CN_W-1:0]   cq_i;
    logic [D_W-1:0]    cd_i;
    logic [D_W:0]      ct;
    logic              cge;
    logic [D_W:0]      cdiff;
    logic [RREM_W-1:0] rrem_o;
    logic [ROW_W-1:0]  rq_o;

    if (s == 0) begin : g_first
      assign vld_i  = c_vld;
      assign pass_i = c_pass;
      assign ok_i   = c_ok;
      assign neg_i  = c_neg;
      assign rrem_i = c_rnum;
      assign rq_i   = '0;
      assign d_i    = c_d;
      assign crem_i = '0;
      assign cn_i   = c_cn;
      assign cq_i   = '0;
      assign cd_i   = c_cd;
    end else begin : g_next
      assign vld_i  = dv_vld[s-1];
      assign pass_i = dv_pass[s-1];
      assign ok_i   = dv_ok[s-1];
      assign neg_i  = dv_neg[s-1];
      assign rrem_i = dv_rrem[s-1];
      assign rq_i   = dv_rq[s-1];
      assign d_i    = dv_d[s-1];
      assign crem_i = dv_crem[s-1];
      assign cn_i   = dv_cn[s-1];
      assign cq_i   = dv_cq[s-1];
      assign cd_i   = dv_cd[s-1];
    end

    if (s < ROW_W) begin : g_row
      logic [RREM_W-1:0] dsh;
      assign dsh    = RREM_W'(d_i) << (ROW_W - 1 - s);
      assign rrem_o = (rrem_i >= dsh) ? rrem_i - dsh : rrem_i;
      always_comb begin
        rq_o = rq_i;
        rq_o[ROW_W-1-s] = rrem_i >= dsh;
      end
    end else begin : g_norow
      assign rrem_o = rrem_i;
      assign rq_o   = rq_i;
    end

    assign ct    = {crem_i, cn_i[CN_W-1]};
    assign cge   = ct >= {1'b0, cd_i};
    assign cdiff = ct - {1'b0, cd_i};

    always_ff @(posedge clk) begin
      if (rst) dv_vld[s] <= 1'b0;
      else dv_vld[s] <= vld_i;
    end

    always_ff @(posedge clk) begin
      dv_pass[s] <= pass_i;
      dv_ok[s]   <= ok_i;
      dv_neg[s]  <= neg_i;
      dv_rrem[s] <= rrem_o;
      dv_rq[s]   <= rq_o;
      dv_d[s]    <= d_i;
      dv_crem[s] <= cge ? cdiff[D_W-1:0] : ct[D_W-1:0];
      dv_cn[s]   <= {cn_i[CN_W-2:0], 1'b0};
      dv_cq[s]   <= {cq_i[CN_W-2:0], cge};
      dv_cd[s]   <= cd_i;
    end
  end

  // Stage E: signed quotient and raw column.
  logic                 e_vld;
  pass_t                e_pass;
  logic                 e_ok;
  logic [ROW_W-1:0]     e_row;
  logic signed [QW-1:0] e_col;
  logic signed [QW-1:0] qa;

  assign qa = QW'(dv_cq[DIV_STAGES-1]);

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else e_vld <= dv_vld[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    e_pass <= dv_pass[DIV_STAGES-1];
    e_ok   <= dv_ok[DIV_STAGES-1];
    e_row  <= dv_rq[DIV_STAGES-1];
    e_col  <= HALF_COLS - (dv_neg[DIV_STAGES-1] ? -qa : qa);
  end

  // Stage F: wrap once and decide validity.
  logic                 f_vld;
  pass_t                f_pass;
  logic                 f_valid;
  logic [ROW_W-1:0]     f_row;
  logic [COL_W-1:0]     f_col;
  logic signed [QW-1:0] col_w;
  logic                 ok_f;

  assign col_w = (e_col >= COLS_S) ? e_col - COLS_S : e_col;
  assign ok_f  = e_ok && (col_w >= 0) && (col_w < COLS_S);

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    f_pass  <= e_pass;
    f_valid <= ok_f;
    f_row   <= ok_f ? e_row : '0;
    f_col   <= ok_f ? col_w[COL_W-1:0] : '0;
  end

  // Stage G: flat index and output registers.
  logic [PW-1:0] flat_idx;

  assign flat_idx = PW'(f_row) * PW'(COLS_U) + PW'(f_col);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= f_vld;
  end

  always_ff @(posedge clk) begin
    point_valid   <= f_valid;
    row           <= 6'(f_row);
    column        <= 11'(f_col);
    cell_index    <= 17'(flat_idx);
    x_out         <= f_pass.xr[19:0];
    y_out         <= f_pass.yr;
    z_out         <= f_pass.zr;
    intensity_out <= f_pass.inten;
  end

endmodule

FILE: src/lidar_point_range_image_projection.sv
// Top level of the lidar range-image projection block: register port,
// front end, queue, square root, CORDIC and row/column back end. Uses rpi_pkg.
//
// Usage: a request is a lidar point on x_in, y_in, z_in and intensity_in,
// taken at a rising edge with start high and busy low. A request can be
// issued every cycle. Each request gives exactly one result, shown for one
// cycle with done high: point_valid, row, column, cell_index and the rotated
// point with its intensity. Results leave in request order.
// From the accepting edge to the edge that takes the result, a request passes
// 2 front-end stages, 1 queue slot, 30 square-root stages (one root bit
// each), 21 CORDIC stages, 3 angle and band stages, 20 column divider
// stages (one quotient bit each) and 3 output stages.
// Throughput is one request per cycle; busy only rises if the queue fills.
// The result side has no stall; the receiver must take every strobe.
// The three registers sit at byte addresses 0, 4 and 8. Through the APB port,
// the user must write them only while no request is in flight (unchecked).
// A synchronous reset empties the pipeline and restores register defaults.
module lidar_point_range_image_projection import rpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [19:0] x_in,
  input  logic signed [19:0] y_in,
  input  logic signed [19:0] z_in,
  input  logic [7:0]         intensity_in,
  output logic               done,
  output logic               point_valid,
  output logic [5:0]         row,
  output logic [10:0]        column,
  output logic [16:0]        cell_index,
  output logic signed [19:0] x_out,
  output logic signed [19:0] y_out,
  output logic signed [19:0] z_out,
  output logic [7:0]         intensity_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t                    cfg;
  logic                    take;
  logic                    wr_en;
  logic                    fe_vld;
  item_t                   fe_item;
  logic                    q_full;
  logic                    q_vld;
  item_t                   q_item;
  logic                    sq_vld;
  pass_t                   sq_pass;
  logic [SQ_RES_W-1:0]     sq_root;
  logic                    co_vld;
  pass_t                   co_pass;
  logic signed [ACC_W-1:0] co_acc_v;
  logic signed [ACC_W-1:0] co_acc_h;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign busy   = q_full;
  assign take   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bottom_angle_offset <= BOTTOM_ANGLE_RST;
      cfg.column_resolution   <= COL_RES_RST;
      cfg.min_planar_range    <= MIN_RANGE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_BOTTOM_ANGLE: cfg.bottom_angle_offset <= pwdata[16:0];
        REG_COL_RES:      cfg.column_resolution   <= pwdata[11:0];
        REG_MIN_RANGE:    cfg.min_planar_range    <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BOTTOM_ANGLE: prdata = {15'd0, cfg.bottom_angle_offset};
      REG_COL_RES:      prdata = {20'd0, cfg.column_resolution};
      REG_MIN_RANGE:    prdata = {18'd0, cfg.min_planar_range};
      default:          prdata = 32'd0;
    endcase
  end

  rpi_front u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .x_in             (x_in),
    .y_in             (y_in),
    .z_in             (z_in),
    .intensity_in     (intensity_in),
    .min_planar_range (cfg.min_planar_range),
    .out_vld          (fe_vld),
    .out_item         (fe_item)
  );

  rpi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fe_vld),
    .push_item (fe_item),
    .full      (q_full),
    .out_vld   (q_vld),
    .out_item  (q_item)
  );

  rpi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (q_vld),
    .in_item  (q_item),
    .out_vld  (sq_vld),
    .out_pass (sq_pass),
    .out_root (sq_root)
  );

  rpi_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (sq_vld),
    .in_pass   (sq_pass),
    .in_root   (sq_root),
    .out_vld   (co_vld),
    .out_pass  (co_pass),
    .out_acc_v (co_acc_v),
    .out_acc_h (co_acc_h)
  );

  rpi_index u_index (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_vld        (co_vld),
    .in_pass       (co_pass),
    .in_acc_v      (co_acc_v),
    .in_acc_h      (co_acc_h),
    .done          (done),
    .point_valid   (point_valid),
    .row           (row),
    .column        (column),
    .cell_index    (cell_index),
    .x_out         (x_out),
    .y_out         (y_out),
    .z_out         (z_out),
    .intensity_out (intensity_out)
  );

endmodule

FILE: src/rpi_checker.sv
// Port-level checks for the range-image projection block, bound to the top
// level. Uses rpi_pkg for the latency and image size.
module rpi_checker import rpi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        point_valid,
  input logic [5:0]  row,
  input logic [10:0] column,
  input logic [16:0] cell_index
);

  // Every result strobe answers a request taken a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !point_valid) |-> (row == 6'd0 && column == 11'd0 && cell_index == 17'd0))
    else $error("rejected point carries a nonzero cell");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (done && point_valid) |-> ({21'd0, column} < 32'(COLUMNS)))
    else $error("column outside the image");

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled although the back end never stalls");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind lidar_point_range_image_projection rpi_checker u_rpi_checker (.*);

FILE: verif/lidar_point_range_image_projection_tb.sv
// Testbench for the lidar range-image projection block: directed and random points
// checked against a built-in projection predictor, with APB register phases.
// Depends on rpi_pkg and lidar_point_range_image_projection.
`timescale 1ns / 1ps

module lidar_point_range_image_projection_tb import rpi_pkg::*;;

  typedef struct {
    logic               valid;
    logic [5:0]         row;
    logic [10:0]        column;
    logic [16:0]        flat;
    logic signed [19:0] xo;
    logic signed [19:0] yo;
    logic signed [19:0] zo;
    logic [7:0]         inten;
  } proj_t;

  logic clk = 0, rst = 1, start = 0;
  logic signed [19:0] x_in = 0, y_in = 0, z_in = 0;
  logic [7:0] intensity_in = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic busy, done, point_valid, pready;
  logic [5:0] row;
  logic [10:0] column;
  logic [16:0] cell_index;
  logic signed [19:0] x_out, y_out, z_out;
  logic [7:0] intensity_out;
  logic [31:0] prdata;

  lidar_point_range_image_projection dut (.*);

  longint bottom_off, col_res, min_range;
  proj_t pending_proj[$];
  int errors = 0;
  longint cycles = 0;
  bit no_gaps = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[lidar_point_range_image_projection] ERROR");
      $finish;
    end
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // Vectoring rotation; the angle is in 1/256 millidegree.
  function automatic longint vec_angle(longint x, longint y);
    longint acc = 0, nx, ny;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + asr(y, i); ny = y - asr(x, i); acc += ATAN_TAB[i];
      end else begin
        nx = x - asr(y, i); ny = y + asr(x, i); acc -= ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    return acc;
  endfunction

  function automatic longint mdeg(longint acc);
    return asr(acc + 128, 8);
  endfunction

  function automatic proj_t project(logic signed [19:0] xi, logic signed [19:0] yi,
                                    logic signed [19:0] zi, logic [7:0] ii);
    longint lim[7] = '{-19000, -14000, -6000, 2000, 3000, 5000, 11000};
    longint bc[8] = '{0, 6000, 11000, 19000, 27000, 28000, 30000, 36000};
    longint bd[8] = '{6000, 5000, 1000, 167, 1000, 2000, 3000, 4000};
    longint bo[8] = '{0, 2, 3, 11, 59, 60, 61, 63};
    longint xr, yr, zr, r2, r, v, m, d, rw = 0, col = 0, a, b, t, pre, h, res, dd, ad, qa;
    int band = 0;
    bit ok = 0;
    proj_t p;
    xr = -longint'(yi); yr = longint'(xi); zr = longint'(zi);
    r2 = xr * xr + yr * yr;
    if (r2 >= min_range * min_range) begin
      r = root_floor(longint'(r2) << 20);
      v = mdeg(vec_angle(r, zr * 1024));
      while (band < 7 && v >= lim[band]) band++;
      d = bd[band];
      m = v + bottom_off - bc[band] + bo[band] * d;
      rw = m / d;
      if (rw >= 0 && rw < ROWS) begin
        a = xr * 1024; b = yr * 1024; pre = 0;
        if (b < 0) begin
          if (a >= 0) begin
            t = a; a = -b; b = t; pre = 90000 * 256;
          end else begin
            t = -a; a = b; b = t; pre = -90000 * 256;
          end
        end
        h = mdeg(pre + vec_angle(b, a));
        res = (col_res == 0) ? 1 : col_res;
        dd = h - 90000;
        ad = dd < 0 ? -dd : dd;
        qa = (2 * ad + res) / (2 * res);
        col = COLUMNS / 2 - (dd < 0 ? -qa : qa);
        if (col >= COLUMNS) col -= COLUMNS;
        ok = (col >= 0 && col < COLUMNS);
      end
    end
    if (!ok) begin
      rw = 0; col = 0;
    end
    p.valid = ok;
    p.row = rw[5:0];
    p.column = col[10:0];
    p.flat = 17'(col + rw * COLUMNS);
    p.xo = xr[19:0];
    p.yo = yr[19:0];
    p.zo = zr[19:0];
    p.inten = ii;
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_proj.size() == 0) report("unexpected result", 1, 0);
      else begin
        proj_t e;
        e = pending_proj.pop_front();
        if (point_valid !== e.valid) report("point_valid", point_valid, e.valid);
        if (row !== e.row) report("row", row, e.row);
        if (column !== e.column) report("column", column, e.column);
        if (cell_index !== e.flat) report("cell_index", cell_index, e.flat);
        if (x_out !== e.xo) report("x_out", x_out, e.xo);
        if (y_out !== e.yo) report("y_out", y_out, e.yo);
        if (z_out !== e.zo) report("z_out", z_out, e.zo);
        if (intensity_out !== e.inten) report("intensity_out", intensity_out, e.inten);
      end
    end
  end

  task automatic send_point(logic signed [19:0] xv, logic signed [19:0] yv,
                            logic signed [19:0] zv, logic [7:0] iv);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1; x_in <= xv; y_in <= yv; z_in <= zv; intensity_in <= iv;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_proj.insert(pending_proj.size(), project(xv, yv, zv, iv));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    wait (pending_proj.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    longint want;
    drain();
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    want = 0;
    case (idx)
      REG_BOTTOM_ANGLE: begin
        bottom_off = val & 32'h1FFFF;
        want = bottom_off;
      end
      REG_COL_RES: begin
        col_res = val & 32'hFFF;
        want = col_res;
      end
      REG_MIN_RANGE: begin
        min_range = val & 32'h3FFF;
        want = min_range;
      end
      default: ;
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    // The address still points at the register just written.
    if (prdata !== 32'(want)) report("prdata", prdata, want);
  endtask

  task automatic set_config(int b, int c, int m);
    write_reg(REG_BOTTOM_ANGLE, b);
    write_reg(REG_COL_RES, c);
    write_reg(REG_MIN_RANGE, m);
  endtask

  function automatic logic signed [19:0] rnd20();
    return 20'($urandom);
  endfunction

  task automatic test_directed();
    send_point(20'sd524287, 20'sd0, 20'sd0, 8'd255);
    send_point(-20'sd524288, 20'sd0, 20'sd0, 8'd0);
    send_point(20'sd0, -20'sd524288, 20'sd524287, 8'd1);
    send_point(20'sd0, 20'sd524287, -20'sd524288, 8'd128);
    send_point(20'sd100, 20'sd100, 20'sd0, 8'd7);
    send_point(20'sd10000, 20'sd0, 20'sd40000, 8'd9);
    send_point(20'sd10000, 20'sd0, -20'sd9000, 8'd9);
    send_point(-20'sd10000, 20'sd0, 20'sd0, 8'd3);
    send_point(20'sd0, 20'sd10000, 20'sd300, 8'd3);
    send_point(20'sd0, -20'sd10000, 20'sd500, 8'd3);
    send_point(-20'sd10000, 20'sd1, 20'sd0, 8'd3);
    send_point(-20'sd10000, -20'sd1, 20'sd0, 8'd3);
    send_point(20'sd1500, 20'sd0, 20'sd0, 8'd2);
    send_point(20'sd1499, 20'sd0, 20'sd0, 8'd2);
    write_reg(REG_MIN_RANGE, 0);
    // With no range limit the origin itself is projected.
    send_point(20'sd0, 20'sd0, 20'sd0, 8'd5);
    send_point(20'sd0, 20'sd0, 20'sd1000, 8'd5);
    send_point(-20'sd524288, -20'sd524288, 20'sd0, 8'd5);
    send_point(20'sd524287, 20'sd524287, 20'sd524287, 8'd5);
  endtask

  task automatic test_random(int count);
    logic signed [19:0] xv, yv, zv;
    int span;
    for (int k = 0; k < count; k++) begin
      if (k % 200 == 100) no_gaps = ~no_gaps;
      if (k == count / 2) drain();
      if ($urandom_range(0, 9) < 8) begin
        span = $urandom_range(0, 1) ? 60000 : 8000;
        xv = 20'($signed($urandom_range(0, 2 * span)) - span);
        yv = 20'($signed($urandom_range(0, 2 * span)) - span);
        zv = 20'(($signed($urandom_range(0, 2 * span)) - span) / 3);
      end else begin
        xv = rnd20(); yv = rnd20(); zv = rnd20();
      end
      send_point(xv, yv, zv, 8'($urandom));
    end
  endtask

  initial begin
    bottom_off = 25000; col_res = 200; min_range = 1500;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    set_config(25000, 200, 1500);
    test_random(400);
    set_config(0, 1, 0);
    test_random(200);
    set_config(90000, 3600, 10000);
    test_random(200);
    set_config(131071, 0, 16383);
    test_random(150);
    set_config(40000, 4095, 1);
    test_random(150);
    set_config(12000, 7, 500);
    test_random(200);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("[lidar_point_range_image_projection] OK");
    else $display("[lidar_point_range_image_projection] ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
src/rpi_pkg.sv
src/rpi_front.sv
src/rpi_queue.sv
src/rpi_sqrt.sv
src/rpi_cordic.sv
src/rpi_index.sv
src/lidar_point_range_image_projection.sv
src/rpi_checker.sv
verif/lidar_point_range_image_projection_tb.sv
